// File: hdl/mfds_pkg.sv
// shared types, constants and the control store of the frame decoder
// no dependencies; every other file of the block refers to it by scoped names
package mfds_pkg;

    localparam int DATA_BYTES  = 21;
    localparam int FIELD_W     = 24;
    localparam int FRAME_W     = DATA_BYTES * 8;
    localparam int POS_W       = 5;
    localparam int ACC_W       = 25;
    localparam int GAIN_W      = 32;
    localparam int STEP_W      = 16;
    localparam int PROD_W      = ACC_W + GAIN_W;
    localparam int FREQ_W      = 20;
    localparam int DCNT_W      = 5;
    localparam int PC_W        = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [POS_W-1:0]  IDLE_POS  = POS_W'(DATA_BYTES + 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(DATA_BYTES);
    localparam logic [POS_W-1:0]  HDR_POS   = '0;
    localparam logic [FREQ_W-1:0] FREQ_NUM  = FREQ_W'(1000000);
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(FREQ_W);

    // field slots inside the captured frame, byte 1 at the bottom
    localparam int FLD_CURR   = 0;
    localparam int FLD_VOLT   = 1;
    localparam int FLD_FAST   = 2;
    localparam int FLD_POWR   = 3;
    localparam int FLD_PULSE  = 4;
    localparam int FLD_PERIOD = 5;
    localparam int FLD_STATUS = 6;

    localparam logic [GAIN_W-1:0] RST_VOLT_GAIN = GAIN_W'(270407);
    localparam logic [GAIN_W-1:0] RST_CURR_GAIN = GAIN_W'(270407);
    localparam logic [GAIN_W-1:0] RST_POWR_GAIN = GAIN_W'(6889682);
    localparam logic [GAIN_W-1:0] RST_ENGY_GAIN = GAIN_W'(801728660);
    localparam logic [STEP_W-1:0] RST_ENGY_STEP = STEP_W'(54);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_GAIN = 3'd0,
        CFG_CURR_GAIN = 3'd1,
        CFG_POWR_GAIN = 3'd2,
        CFG_ENGY_GAIN = 3'd3,
        CFG_ENGY_STEP = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] volt_gain;
        logic [GAIN_W-1:0] curr_gain;
        logic [GAIN_W-1:0] powr_gain;
        logic [GAIN_W-1:0] engy_gain;
        logic [STEP_W-1:0] engy_step;
    } t_cfg;

    typedef enum logic [1:0] {
        MS_VOLT,
        MS_CURR,
        MS_POWR,
        MS_ENGY
    } t_mul_sel;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_VOLT,
        DST_CURR,
        DST_POWR
    } t_dst;

    typedef enum logic {
        JC_NONE,
        JC_DIV_MORE
    } t_jcond;

    // one control word of the frame-end microprogram
    typedef struct packed {
        logic            acc_add;
        logic            div_init;
        logic            mul_en;
        t_mul_sel        mul_sel;
        t_dst            dst;
        logic            energy_upd;
        logic            div_step;
        t_jcond          jcond;
        logic [PC_W-1:0] jmp;
        logic            finish;
    } t_ucode;

    typedef struct packed {
        logic [FIELD_W-1:0] voltage;
        logic [FIELD_W-1:0] current;
        logic [FIELD_W-1:0] power;
        logic [FREQ_W-1:0]  frequency;
        logic [GAIN_W-1:0]  energy_total;
    } t_result;

    localparam t_ucode UC_NOP = '{
        acc_add: 1'b0, div_init: 1'b0, mul_en: 1'b0, mul_sel: MS_VOLT,
        dst: DST_NONE, energy_upd: 1'b0, div_step: 1'b0, jcond: JC_NONE,
        jmp: '0, finish: 1'b0
    };

    localparam logic [PC_W-1:0] PC_DIV = 3'd6;

    // control store
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode uc;
        uc = UC_NOP;
        unique case (pc)
            3'd0: begin
                uc.acc_add  = 1'b1;
                uc.div_init = 1'b1;
            end
            3'd1: begin
                uc.mul_en  = 1'b1;
                uc.mul_sel = MS_VOLT;
            end
            3'd2: begin
                uc.dst     = DST_VOLT;
                uc.mul_en  = 1'b1;
                uc.mul_sel = MS_CURR;
            end
            3'd3: begin
                uc.dst     = DST_CURR;
                uc.mul_en  = 1'b1;
                uc.mul_sel = MS_POWR;
            end
            3'd4: begin
                uc.dst     = DST_POWR;
                uc.mul_en  = 1'b1;
                uc.mul_sel = MS_ENGY;
            end
            3'd5: begin
                uc.energy_upd = 1'b1;
            end
            3'd6: begin
                uc.div_step = 1'b1;
                uc.jcond    = JC_DIV_MORE;
                uc.jmp      = PC_DIV;
            end
            3'd7: begin
                uc.finish = 1'b1;
            end
            default: begin
                uc = UC_NOP;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: hdl/mfds_if.sv
// valid/ready channel interfaces for frame bytes and decoded results
// depends on mfds_pkg for field widths
interface mfds_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_first;

    modport source (output valid, output rx_byte, output frame_first, input ready);
    modport sink   (input valid, input rx_byte, input frame_first, output ready);
endinterface

interface mfds_out_if;
    logic                             valid;
    logic                             ready;
    logic [mfds_pkg::FIELD_W-1:0]     voltage;
    logic [mfds_pkg::FIELD_W-1:0]     current;
    logic [mfds_pkg::FIELD_W-1:0]     power;
    logic [mfds_pkg::FREQ_W-1:0]      frequency;
    logic [mfds_pkg::FIELD_W-1:0]     fast_current_raw;
    logic [mfds_pkg::FIELD_W-1:0]     status_raw;
    logic [mfds_pkg::GAIN_W-1:0]      energy_total;

    modport source (
        output valid, output voltage, output current, output power, output frequency,
        output fast_current_raw, output status_raw, output energy_total, input ready
    );
    modport sink (
        input valid, input voltage, input current, input power, input frequency,
        input fast_current_raw, input status_raw, input energy_total, output ready
    );
endinterface

// File: hdl/mfds_seq.sv
// microprogram sequencer: step counter, control store lookup, divider loop
// depends on mfds_pkg (t_ucode, ucode_rom)
module mfds_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_div_more,
    input  logic                 i_out_free,
    output mfds_pkg::t_ucode     o_ctl,
    output logic                 o_busy
);

    logic [mfds_pkg::PC_W-1:0] r_pc;
    logic                      r_busy;
    mfds_pkg::t_ucode          uc;

    always_comb begin
        uc = r_busy ? mfds_pkg::ucode_rom(r_pc) : mfds_pkg::UC_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end
        end else if (uc.finish) begin
            // hold on the last step until the result register is free
            if (i_out_free) begin
                r_busy <= 1'b0;
                r_pc   <= '0;
            end
        end else if (uc.jcond == mfds_pkg::JC_DIV_MORE && i_div_more) begin
            r_pc <= uc.jmp;
        end else begin
            r_pc <= r_pc + 1'b1;
        end
    end

    assign o_ctl  = uc;
    assign o_busy = r_busy;

endmodule

// File: hdl/mfds_dp.sv
// datapath: shared multiplier, restoring divider, pulse accumulator, energy sum
// depends on mfds_pkg; driven by control words from mfds_seq
module mfds_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mfds_pkg::t_ucode              i_ctl,
    input  mfds_pkg::t_cfg                i_cfg,
    input  logic [mfds_pkg::FRAME_W-1:0]  i_frame,
    output logic                          o_div_more,
    output mfds_pkg::t_result             o_res
);

    localparam int FW = mfds_pkg::FIELD_W;

    logic [FW-1:0] volt_raw, curr_raw, powr_raw, pulse_raw, period_raw;

    assign curr_raw   = i_frame[mfds_pkg::FLD_CURR   * FW +: FW];
    assign volt_raw   = i_frame[mfds_pkg::FLD_VOLT   * FW +: FW];
    assign powr_raw   = i_frame[mfds_pkg::FLD_POWR   * FW +: FW];
    assign pulse_raw  = i_frame[mfds_pkg::FLD_PULSE  * FW +: FW];
    assign period_raw = i_frame[mfds_pkg::FLD_PERIOD * FW +: FW];

    logic [mfds_pkg::ACC_W-1:0]  mul_a;
    logic [mfds_pkg::GAIN_W-1:0] mul_b;
    logic [mfds_pkg::PROD_W-1:0] r_prod;
    logic [mfds_pkg::ACC_W-1:0]  r_acc;
    logic [mfds_pkg::GAIN_W-1:0] r_esum;
    logic [FW-1:0]               r_volt, r_curr, r_powr;

    logic [FW-1:0]                r_rem;
    logic [mfds_pkg::FREQ_W-1:0]  r_quo;
    logic [mfds_pkg::FREQ_W-1:0]  r_num;
    logic [mfds_pkg::DCNT_W-1:0]  r_dcnt;
    logic [FW:0]                  rem_sh;
    logic [FW:0]                  rem_diff;
    logic                         rem_ge;

    always_comb begin
        case (i_ctl.mul_sel)
            mfds_pkg::MS_VOLT: begin
                mul_a = mfds_pkg::ACC_W'(volt_raw);
                mul_b = i_cfg.volt_gain;
            end
            mfds_pkg::MS_CURR: begin
                mul_a = mfds_pkg::ACC_W'(curr_raw);
                mul_b = i_cfg.curr_gain;
            end
            mfds_pkg::MS_POWR: begin
                mul_a = mfds_pkg::ACC_W'(powr_raw);
                mul_b = i_cfg.powr_gain;
            end
            default: begin
                mul_a = r_acc;
                mul_b = i_cfg.engy_gain;
            end
        endcase
    end

    // one quotient bit per step
    assign rem_sh   = {r_rem, r_num[mfds_pkg::FREQ_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, period_raw};
    assign rem_diff = rem_sh - {1'b0, period_raw};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= mfds_pkg::PROD_W'(mul_a) * mfds_pkg::PROD_W'(mul_b);
        end
        case (i_ctl.dst)
            mfds_pkg::DST_VOLT: r_volt <= r_prod[mfds_pkg::GAIN_W +: FW];
            mfds_pkg::DST_CURR: r_curr <= r_prod[mfds_pkg::GAIN_W +: FW];
            mfds_pkg::DST_POWR: r_powr <= r_prod[mfds_pkg::GAIN_W +: FW];
            default: ;
        endcase
        if (i_ctl.div_init) begin
            r_rem  <= '0;
            r_quo  <= '0;
            r_num  <= mfds_pkg::FREQ_NUM;
            r_dcnt <= mfds_pkg::DIV_STEPS;
        end else if (i_ctl.div_step) begin
            r_rem  <= rem_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
            r_quo  <= {r_quo[mfds_pkg::FREQ_W-2:0], rem_ge};
            r_num  <= {r_num[mfds_pkg::FREQ_W-2:0], 1'b0};
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_esum <= '0;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + mfds_pkg::ACC_W'(pulse_raw);
        end else if (i_ctl.energy_upd && r_acc >= mfds_pkg::ACC_W'(i_cfg.engy_step)) begin
            r_esum <= r_esum + mfds_pkg::GAIN_W'(r_prod[mfds_pkg::PROD_W-1:mfds_pkg::GAIN_W]);
            r_acc  <= '0;
        end
    end

    assign o_div_more = r_dcnt != mfds_pkg::DCNT_W'(1);

    assign o_res.voltage      = r_volt;
    assign o_res.current      = r_curr;
    assign o_res.power        = r_powr;
    assign o_res.frequency    = (period_raw == '0) ? mfds_pkg::FREQ_NUM : r_quo;
    assign o_res.energy_total = r_esum;

endmodule

// File: hdl/meter_frame_decode_scale.sv
// top level of the energy-meter response frame decoder and scaler
// depends on mfds_pkg, mfds_if, mfds_seq and mfds_dp
//
// Takes one frame byte per transaction on i_rx; a byte flagged frame_first is
// the header and restarts the frame, bytes outside a frame are dropped. Data
// bytes are taken at one per clock unless a frame end is in flight. Once the
// 21st data byte is in, an eight-step microprogram runs on a shared 25x32
// multiplier and a one-bit-per-clock restoring divider, which does the
// 1000000 / period divide; i_rx.ready is low meanwhile. The result sits in
// an output register, so bytes of the next frame are taken while it waits on
// o_res; only a second frame end held behind an unread result stalls the
// microprogram on its last step. Configuration writes go straight into the
// gain and step registers and should only be made with no frame end in flight.
module meter_frame_decode_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mfds_in_if.sink                         i_rx,
    mfds_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [mfds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfds_pkg::GAIN_W-1:0]     i_cfg_data
);

    localparam int FW = mfds_pkg::FIELD_W;

    // configuration registers
    mfds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volt_gain <= mfds_pkg::RST_VOLT_GAIN;
            r_cfg.curr_gain <= mfds_pkg::RST_CURR_GAIN;
            r_cfg.powr_gain <= mfds_pkg::RST_POWR_GAIN;
            r_cfg.engy_gain <= mfds_pkg::RST_ENGY_GAIN;
            r_cfg.engy_step <= mfds_pkg::RST_ENGY_STEP;
        end else if (i_cfg_we) begin
            case (mfds_pkg::t_cfg_idx'(i_cfg_idx))
                mfds_pkg::CFG_VOLT_GAIN: r_cfg.volt_gain <= i_cfg_data;
                mfds_pkg::CFG_CURR_GAIN: r_cfg.curr_gain <= i_cfg_data;
                mfds_pkg::CFG_POWR_GAIN: r_cfg.powr_gain <= i_cfg_data;
                mfds_pkg::CFG_ENGY_GAIN: r_cfg.engy_gain <= i_cfg_data;
                mfds_pkg::CFG_ENGY_STEP: r_cfg.engy_step <= i_cfg_data[mfds_pkg::STEP_W-1:0];
                default: ;  // unused register indexes are ignored
            endcase
        end
    end

    // byte capture: position counter and a shift line holding the data bytes
    logic [mfds_pkg::POS_W-1:0]   r_pos;
    logic [mfds_pkg::FRAME_W-1:0] r_frame;
    logic                         rx_take;
    logic                         start;
    logic                         seq_busy;

    assign i_rx.ready = !seq_busy;
    assign rx_take    = i_rx.valid && i_rx.ready;
    assign start      = rx_take && !i_rx.frame_first && r_pos == mfds_pkg::LAST_POS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= mfds_pkg::IDLE_POS;
        end else if (rx_take) begin
            if (i_rx.frame_first) begin
                r_pos <= mfds_pkg::HDR_POS;
            end else if (r_pos == mfds_pkg::LAST_POS) begin
                r_pos <= mfds_pkg::IDLE_POS;
            end else if (r_pos == mfds_pkg::HDR_POS) begin
                // first data byte lands on position one, counter moves past it
                r_pos <= mfds_pkg::POS_W'(2);
            end else if (r_pos != mfds_pkg::IDLE_POS) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // after 21 shifts since the header, byte one sits at the bottom
    always_ff @(posedge i_clk) begin
        if (rx_take && !i_rx.frame_first && r_pos != mfds_pkg::IDLE_POS) begin
            r_frame <= {i_rx.rx_byte, r_frame[mfds_pkg::FRAME_W-1:8]};
        end
    end

    // microprogram and datapath
    mfds_pkg::t_ucode  ctl;
    mfds_pkg::t_result dp_res;
    logic              div_more;
    logic              out_free;
    logic              emit;

    mfds_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_div_more (div_more),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_busy     (seq_busy)
    );

    mfds_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cfg      (r_cfg),
        .i_frame    (r_frame),
        .o_div_more (div_more),
        .o_res      (dp_res)
    );

    // result register, parts the sequencer from the downstream stall
    logic              r_out_valid;
    mfds_pkg::t_result r_out;
    logic [FW-1:0]     r_out_fast;
    logic [FW-1:0]     r_out_status;

    assign out_free = !r_out_valid || o_res.ready;
    assign emit     = ctl.finish && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out        <= dp_res;
            r_out_fast   <= r_frame[mfds_pkg::FLD_FAST * FW +: FW];
            r_out_status <= r_frame[mfds_pkg::FLD_STATUS * FW +: FW];
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.voltage          = r_out.voltage;
    assign o_res.current          = r_out.current;
    assign o_res.power            = r_out.power;
    assign o_res.frequency        = r_out.frequency;
    assign o_res.fast_current_raw = r_out_fast;
    assign o_res.status_raw       = r_out_status;
    assign o_res.energy_total     = r_out.energy_total;

endmodule

// File: hdl/mfds_chk.sv
// port-level checks of the frame decoder, attached to the top level by bind
// depends on mfds_pkg for widths and the frequency ceiling
module mfds_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mfds_pkg::FREQ_W-1:0]   i_frequency
);

    // a result only appears after the microprogram held off input bytes
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised without a busy frame-end phase");

    // the divider never exceeds its saturation value
    a_freq_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frequency <= mfds_pkg::FREQ_NUM)
        else $error("frequency above ceiling");

    // a stalled result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // when a result rises, input is held off now or was held off before the last microprogram step
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready || $past(!i_in_ready, 2))
        else $error("input taken while frame end was being processed");

endmodule

bind meter_frame_decode_scale mfds_chk u_mfds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_frequency (o_res.frequency)
);

// File: tb/tb_meter_frame_decode_scale.sv
`timescale 1ns / 1ps
// self-checking testbench for meter_frame_decode_scale: sends response frames byte by byte,
// predicts every decoded reading and compares it field by field with what the block returns
// depends on mfds_pkg, mfds_if and the block itself
module tb_meter_frame_decode_scale;

    localparam int FIELD_W   = mfds_pkg::FIELD_W;
    localparam int GAIN_W    = mfds_pkg::GAIN_W;
    localparam int STEP_W    = mfds_pkg::STEP_W;
    localparam int FREQ_W    = mfds_pkg::FREQ_W;
    localparam int POS_W     = mfds_pkg::POS_W;
    localparam int FRAME_W   = mfds_pkg::FRAME_W;
    localparam int ACC_W     = mfds_pkg::ACC_W;
    localparam int PROD_W    = mfds_pkg::PROD_W;
    localparam int CFG_IDX_W = mfds_pkg::CFG_IDX_W;

    localparam int SETTLE_CYCLES  = 40;    // margin for the frame-end microprogram to finish
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 320;
    localparam int IDLE_PERCENT   = 15;
    localparam int MAX_REPORTS    = 10;

    // indexes past the last register, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST =
        CFG_IDX_W'(int'(mfds_pkg::CFG_ENGY_STEP) + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
    localparam logic [STEP_W-1:0]  STEP_MAX  = '1;

    // one decoded reading, in the order the block presents it
    typedef struct packed {
        logic [FIELD_W-1:0] voltage;
        logic [FIELD_W-1:0] current;
        logic [FIELD_W-1:0] power;
        logic [FREQ_W-1:0]  frequency;
        logic [FIELD_W-1:0] fast_current_raw;
        logic [FIELD_W-1:0] status_raw;
        logic [GAIN_W-1:0]  energy_total;
    } t_meter_reading;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [GAIN_W-1:0]    i_cfg_data = '0;

    mfds_in_if  rx_ch ();
    mfds_out_if res_ch ();

    meter_frame_decode_scale dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state: a copy of the register file and of the frame decoder
    mfds_pkg::t_cfg     meter_cfg;
    logic [POS_W-1:0]   frame_pos;
    logic [FRAME_W-1:0] captured_frame;
    logic [ACC_W-1:0]   pulse_total;
    logic [GAIN_W-1:0]  energy_milli;
    t_meter_reading     pending_readings[$];

    // traffic shaping shared by the sender, the receiver and the hold-off process
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    bit hold_on;

    int bytes_taken      = 0;
    int readings_checked = 0;
    int register_writes  = 0;
    int mismatches       = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void reset_meter_model();
        meter_cfg.volt_gain = mfds_pkg::RST_VOLT_GAIN;
        meter_cfg.curr_gain = mfds_pkg::RST_CURR_GAIN;
        meter_cfg.powr_gain = mfds_pkg::RST_POWR_GAIN;
        meter_cfg.engy_gain = mfds_pkg::RST_ENGY_GAIN;
        meter_cfg.engy_step = mfds_pkg::RST_ENGY_STEP;
        frame_pos           = mfds_pkg::IDLE_POS;
        captured_frame      = '0;
        pulse_total         = '0;
        energy_milli        = '0;
    endfunction

    // Q0.32 gain applied to a 24-bit raw field, fraction dropped
    function automatic logic [FIELD_W-1:0] scale_q32(input logic [FIELD_W-1:0] raw,
                                                     input logic [GAIN_W-1:0] gain);
        logic [FIELD_W+GAIN_W-1:0] prod;
        prod = raw * gain;
        return prod[FIELD_W+GAIN_W-1:GAIN_W];
    endfunction

    function automatic logic [FIELD_W-1:0] stored_field(input int slot);
        return captured_frame[slot*FIELD_W +: FIELD_W];
    endfunction

    // advances the decoder by one byte; returns 0 when the byte is dropped outside a frame
    function automatic bit decode_frame_byte(input logic [7:0] rx, input logic first);
        t_meter_reading     reading;
        logic [FIELD_W-1:0] period;
        logic [PROD_W-1:0]  energy_prod;
        // header value is never checked, it only restarts the count
        if (first) begin
            frame_pos = mfds_pkg::HDR_POS;
            return 1'b1;
        end
        if (frame_pos == mfds_pkg::HDR_POS) begin
            frame_pos = POS_W'(1);
        end else if (frame_pos > mfds_pkg::LAST_POS) begin
            return 1'b0;
        end
        captured_frame[(int'(frame_pos) - 1) * 8 +: 8] = rx;
        if (frame_pos < mfds_pkg::LAST_POS) begin
            frame_pos = frame_pos + POS_W'(1);
            return 1'b1;
        end
        frame_pos = mfds_pkg::IDLE_POS;

        // pulses accumulate until the threshold, then turn into energy in one go
        pulse_total = pulse_total + stored_field(mfds_pkg::FLD_PULSE);
        if (pulse_total >= meter_cfg.engy_step) begin
            energy_prod  = pulse_total * meter_cfg.engy_gain;
            energy_milli = energy_milli + energy_prod[PROD_W-1:GAIN_W];
            pulse_total  = '0;
        end

        period                   = stored_field(mfds_pkg::FLD_PERIOD);
        reading.voltage          = scale_q32(stored_field(mfds_pkg::FLD_VOLT),
                                             meter_cfg.volt_gain);
        reading.current          = scale_q32(stored_field(mfds_pkg::FLD_CURR),
                                             meter_cfg.curr_gain);
        reading.power            = scale_q32(stored_field(mfds_pkg::FLD_POWR),
                                             meter_cfg.powr_gain);
        reading.frequency        = (period == '0) ? mfds_pkg::FREQ_NUM
                                                  : FREQ_W'(mfds_pkg::FREQ_NUM / period);
        reading.fast_current_raw = stored_field(mfds_pkg::FLD_FAST);
        reading.status_raw       = stored_field(mfds_pkg::FLD_STATUS);
        reading.energy_total     = energy_milli;
        pending_readings.push_back(reading);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in reading %0d, %s: expected %0d, got %0d",
                         readings_checked, name, want, got);
        end
    endfunction

    function automatic void check_reading();
        t_meter_reading want;
        if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("reading returned with none outstanding: voltage %0d energy %0d",
                         res_ch.voltage, res_ch.energy_total);
            return;
        end
        want = pending_readings.pop_front();
        compare_field("voltage", want.voltage, res_ch.voltage);
        compare_field("current", want.current, res_ch.current);
        compare_field("power", want.power, res_ch.power);
        compare_field("frequency", want.frequency, res_ch.frequency);
        compare_field("fast_current_raw", want.fast_current_raw, res_ch.fast_current_raw);
        compare_field("status_raw", want.status_raw, res_ch.status_raw);
        compare_field("energy_total", want.energy_total, res_ch.energy_total);
        readings_checked++;
    endfunction

    // result side: checks each transaction, idles at random, or holds off on request
    initial begin : result_sink
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                check_reading();
            if (!i_rst_n || hold_on)
                res_ch.ready <= 1'b0;
            else if (no_idle)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // long hold-off on the result side, counted here so the sender keeps pushing meanwhile
    initial begin : receiver_hold
        hold_on = 1'b0;
        forever begin
            wait (hold_req);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
            wait (!hold_req);
        end
    end

    // ends the run when neither channel has moved a transaction for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles, %0d readings outstanding",
                 quiet, pending_readings.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // valid stays high into the next byte when there is no gap, so no lower/raise in one step
    task automatic send_byte(input logic [7:0] rx, input logic first);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= rx;
        rx_ch.frame_first <= first;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        if (decode_frame_byte(rx, first))
            bytes_taken++;
    endtask

    task automatic send_data_bytes(input logic [FRAME_W-1:0] payload, input int count);
        for (int i = 0; i < count; i++)
            send_byte(payload[i*8 +: 8], 1'b0);
    endtask

    task automatic send_frame(input logic [7:0] header, input logic [FRAME_W-1:0] payload);
        send_byte(header, 1'b1);
        send_data_bytes(payload, mfds_pkg::DATA_BYTES);
    endtask

    // drops valid, waits for every reading, then lets the microprogram settle
    task automatic finish_outstanding();
        rx_ch.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [GAIN_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            mfds_pkg::CFG_VOLT_GAIN: meter_cfg.volt_gain = value;
            mfds_pkg::CFG_CURR_GAIN: meter_cfg.curr_gain = value;
            mfds_pkg::CFG_POWR_GAIN: meter_cfg.powr_gain = value;
            mfds_pkg::CFG_ENGY_GAIN: meter_cfg.engy_gain = value;
            mfds_pkg::CFG_ENGY_STEP: meter_cfg.engy_step = value[STEP_W-1:0];
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic set_config(input logic [GAIN_W-1:0] volt, input logic [GAIN_W-1:0] curr,
                              input logic [GAIN_W-1:0] powr, input logic [GAIN_W-1:0] engy,
                              input logic [STEP_W-1:0] step);
        write_register(mfds_pkg::CFG_VOLT_GAIN, volt);
        write_register(mfds_pkg::CFG_CURR_GAIN, curr);
        write_register(mfds_pkg::CFG_POWR_GAIN, powr);
        write_register(mfds_pkg::CFG_ENGY_GAIN, engy);
        write_register(mfds_pkg::CFG_ENGY_STEP, GAIN_W'(step));
    endtask

    function automatic logic [FRAME_W-1:0] pack_fields(
        input logic [FIELD_W-1:0] curr, volt, fast, powr, pulses, period, status);
        logic [FRAME_W-1:0] payload;
        payload[mfds_pkg::FLD_CURR*FIELD_W   +: FIELD_W] = curr;
        payload[mfds_pkg::FLD_VOLT*FIELD_W   +: FIELD_W] = volt;
        payload[mfds_pkg::FLD_FAST*FIELD_W   +: FIELD_W] = fast;
        payload[mfds_pkg::FLD_POWR*FIELD_W   +: FIELD_W] = powr;
        payload[mfds_pkg::FLD_PULSE*FIELD_W  +: FIELD_W] = pulses;
        payload[mfds_pkg::FLD_PERIOD*FIELD_W +: FIELD_W] = period;
        payload[mfds_pkg::FLD_STATUS*FIELD_W +: FIELD_W] = status;
        return payload;
    endfunction

    // biased towards the ends of the range
    function automatic logic [FIELD_W-1:0] random_field();
        case ($urandom_range(7))
            0:       return '0;
            1:       return FIELD_MAX;
            2:       return FIELD_W'($urandom_range(255));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // small periods dominate so the quotient stays interesting
    function automatic logic [FIELD_W-1:0] random_period();
        case ($urandom_range(7))
            0:       return '0;
            1:       return FIELD_MAX;
            2:       return FIELD_W'($urandom);
            default: return FIELD_W'($urandom_range(2000, 1));
        endcase
    endfunction

    // mostly a few pulses per frame, so the accumulator builds up over several frames
    function automatic logic [FIELD_W-1:0] random_pulses();
        case ($urandom_range(9))
            0:       return FIELD_MAX;
            1:       return FIELD_W'($urandom);
            default: return FIELD_W'($urandom_range(120));
        endcase
    endfunction

    function automatic logic [FRAME_W-1:0] random_payload();
        return pack_fields(random_field(), random_field(), random_field(), random_field(),
                           random_pulses(), random_period(), random_field());
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return GAIN_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(5))
            0:       return STEP_W'(1);
            1:       return STEP_MAX;
            2:       return STEP_W'($urandom_range(STEP_MAX, 1));
            default: return STEP_W'($urandom_range(200, 1));
        endcase
    endfunction

    // mostly clean frames; the rest stray bytes, cut-short frames and repeated headers
    task automatic random_frame_traffic();
        case ($urandom_range(9))
            0: repeat ($urandom_range(4, 1)) send_byte(8'($urandom), 1'b0);
            1: begin
                send_byte(8'($urandom), 1'b1);
                send_data_bytes(random_payload(), $urandom_range(mfds_pkg::DATA_BYTES - 1, 1));
            end
            2: begin
                send_byte(8'($urandom), 1'b1);
                send_frame(8'($urandom), random_payload());
            end
            default: send_frame(8'($urandom), random_payload());
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset gains: zero frame, all-ones frame, period of one, threshold reached exactly
    task automatic test_reset_defaults();
        send_frame(8'h55, '0);
        send_frame(8'hFF, '1);
        send_frame(8'h00, pack_fields(24'd1000, 24'd230000, 24'd7, 24'd5000,
                                      24'd53, 24'd1, 24'h00A5A5));
        send_frame(8'h58, pack_fields(24'd12345, 24'd3500000, 24'h5A5A5A, 24'd800000,
                                      24'd1, 24'd3, 24'hFF00FF));
        finish_outstanding();
    endtask

    // stray bytes dropped, header restarting a frame part way, header after header
    task automatic test_frame_sync();
        repeat (3) send_byte(8'($urandom), 1'b0);
        send_byte(8'h58, 1'b1);
        send_data_bytes(random_payload(), 10);
        send_frame(8'h58, random_payload());
        send_byte(8'hAA, 1'b1);
        send_frame(8'h00, random_payload());
        repeat (2) send_byte(8'($urandom), 1'b0);
        finish_outstanding();
    endtask

    // zero and full-scale gains, smallest and largest threshold, zero threshold, spare indexes
    task automatic test_register_extremes();
        set_config('0, '0, '0, '0, STEP_MAX);
        send_frame(8'h58, '1);
        finish_outstanding();
        set_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, STEP_W'(1));
        send_frame(8'h58, '1);
        send_frame(8'h58, pack_fields(24'd1, 24'd1, 24'd0, 24'd1, 24'd0, 24'd999999, 24'd0));
        finish_outstanding();
        // zero threshold converts on every frame end, even with no pulses
        write_register(mfds_pkg::CFG_ENGY_STEP, '0);
        send_frame(8'h58, pack_fields(24'd9, 24'd9, 24'd9, 24'd9, 24'd0, 24'd1000000, 24'd9));
        send_frame(8'h58, pack_fields(24'd9, 24'd9, 24'd9, 24'd9, 24'd5, 24'd1000001, 24'd9));
        finish_outstanding();
        write_register(CFG_SPARE_FIRST, '0);
        write_register(CFG_SPARE_LAST, GAIN_MAX);
        send_frame(8'h58, random_payload());
        finish_outstanding();
    endtask

    // a stretch with no idling on either side
    task automatic test_back_to_back();
        set_config(mfds_pkg::RST_VOLT_GAIN, mfds_pkg::RST_CURR_GAIN, mfds_pkg::RST_POWR_GAIN,
                   mfds_pkg::RST_ENGY_GAIN, mfds_pkg::RST_ENGY_STEP);
        no_idle = 1'b1;
        repeat (6) send_frame(8'($urandom), random_payload());
        finish_outstanding();
        no_idle = 1'b0;
    endtask

    // result side holds off while frames keep coming, so the block must stall its input
    task automatic test_output_holdoff();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (4) send_frame(8'($urandom), random_payload());
        hold_req = 1'b0;
        finish_outstanding();
        no_idle = 1'b0;
    endtask

    // random settings per phase, random frame traffic within
    task automatic test_random_traffic();
        int target;
        target = bytes_taken + RANDOM_ITEMS;
        while (bytes_taken < target) begin
            set_config(random_gain(), random_gain(), random_gain(), random_gain(),
                       random_step());
            repeat ($urandom_range(10, 4)) random_frame_traffic();
            finish_outstanding();
        end
    endtask

    initial begin
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = '0;
        rx_ch.frame_first = 1'b0;
        reset_meter_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_frame_sync();
        test_register_extremes();
        test_back_to_back();
        test_output_holdoff();
        test_random_traffic();
        finish_outstanding();

        $display("run covered %0d frame bytes, %0d readings checked, %0d register writes",
                 bytes_taken, readings_checked, register_writes);
        $display("incl. header resync, stray bytes, cut-short frames, extreme settings, %0s",
                 "a long result hold-off");
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d readings missing", mismatches,
                     pending_readings.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
